// ----- src/wgdd_pkg.sv -----
// Package for the wait-for graph deadlock detector.
// Holds field widths, opcodes and the timeout reset value; no dependencies.
`default_nettype none

package wgdd_pkg;

    // Field widths of one input word and one result word.
    localparam int OP_W    = 2;
    localparam int AGENT_W = 4;
    localparam int TIME_W  = 32;

    // Opcodes of an input word.
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    // Timeout after reset: 30.0 s held as whole milliseconds.
    localparam logic [TIME_W-1:0] TIMEOUT_RESET_MS = 32'd30000;

endpackage

`default_nettype wire

// ----- src/wait_graph_deadlock_detector_top.sv -----
// Wait-for graph deadlock detector, top level and only module.
// Depends on wgdd_pkg for widths, opcodes and the timeout reset value.
//
// A record or clear word (and the unused opcode) is accepted and its all-zero
// result word is registered in the cycle after. A check word runs a small
// sequencer over one table read port: for each waiting start agent it follows
// up to AGENTS wait-for links through S_TEST and S_READ; once a cycle is found it scans
// all AGENTS wait start times through S_SCAN_RD and S_SCAN_CMP with one
// subtract-and-compare unit. The input is not ready during a check, and a word
// is only accepted when the output register is free or being emptied. No
// clearing pass is needed after reset.
`default_nettype none

module wait_graph_deadlock_detector_top #(
    parameter int AGENTS = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration port.
    input  wire                                i_cfg_we,
    input  wire  [wgdd_pkg::TIME_W-1:0]        i_cfg_wdata,
    // Input channel.
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [wgdd_pkg::OP_W-1:0]          i_opcode,
    input  wire  [wgdd_pkg::AGENT_W-1:0]       i_agent,
    input  wire  [wgdd_pkg::AGENT_W-1:0]       i_blocker,
    input  wire  [wgdd_pkg::TIME_W-1:0]        i_now_ms,
    // Output channel.
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_cycle_found,
    output logic                               o_victim_valid,
    output logic [wgdd_pkg::AGENT_W-1:0]       o_victim,
    output logic                               o_release_res
);

    localparam int IW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
    localparam int CW = ((IW > wgdd_pkg::AGENT_W) ? IW : wgdd_pkg::AGENT_W) + 1;
    localparam int TW = wgdd_pkg::TIME_W;
    localparam int AW = wgdd_pkg::AGENT_W;

    localparam logic [CW-1:0]   AGENTS_C = CW'(AGENTS);
    localparam logic [IW-1:0]   LAST_IDX = IW'(AGENTS - 1);
    localparam logic [IW:0]     LAST_STEP = (IW+1)'(AGENTS);

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_TEST     = 3'd2;
    localparam logic [2:0] S_READ     = 3'd3;
    localparam logic [2:0] S_SCAN_RD  = 3'd4;
    localparam logic [2:0] S_SCAN_CMP = 3'd5;
    localparam logic [2:0] S_DECIDE   = 3'd6;

    // Registers.
    logic [2:0]        r_state, n_state;
    logic [IW-1:0]     r_start, n_start;
    logic [IW:0]       r_step, n_step;
    logic [AW-1:0]     r_node, n_node;
    logic [IW-1:0]     r_scan, n_scan;
    logic [TW-1:0]     r_best, n_best;
    logic [IW-1:0]     r_victim, n_victim;
    logic              r_found, n_found;
    logic              r_cycle, n_cycle;
    logic [TW-1:0]     r_now;
    logic [TW-1:0]     r_timeout;
    logic [AGENTS-1:0] r_waiting;

    // Table memories, one read port each with registered data.
    logic [AW-1:0]     r_wf_mem [AGENTS];
    logic [TW-1:0]     r_ws_mem [AGENTS];
    logic [AW-1:0]     r_wf_q;
    logic [TW-1:0]     r_ws_q;

    logic              in_acc;
    logic              slot_free;
    logic              out_load;
    logic              out_cycle, out_vv, out_rel;
    logic [CW-1:0]     agent_x, node_x, victim_x;
    logic              agent_ok, node_ok;
    logic [IW-1:0]     agent_idx, node_idx;
    logic [TW-1:0]     wait_ms;
    logic              is_record, is_clear, is_check;

    // Index arithmetic for the agent field and the walk pointer.
    always_comb begin
        agent_x   = CW'(i_agent);
        agent_ok  = agent_x < AGENTS_C;
        agent_idx = agent_x[IW-1:0];
        node_x    = CW'(r_node);
        node_ok   = node_x < AGENTS_C;
        node_idx  = node_x[IW-1:0];
        victim_x  = CW'(r_victim);
        wait_ms   = r_now - r_ws_q;
    end

    // Handshake on the input side.
    assign slot_free  = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_record  = (i_opcode == wgdd_pkg::OP_RECORD);
    assign is_clear   = (i_opcode == wgdd_pkg::OP_CLEAR);
    assign is_check   = (i_opcode == wgdd_pkg::OP_CHECK);

    // Result of a finished check.
    assign out_cycle = r_cycle;
    assign out_vv    = r_cycle && r_found;
    assign out_rel   = out_vv && (r_best >= r_timeout);

    // Sequencer: cycle search walk, then the longest-wait scan.
    always_comb begin
        n_state  = r_state;
        n_start  = r_start;
        n_step   = r_step;
        n_node   = r_node;
        n_scan   = r_scan;
        n_best   = r_best;
        n_victim = r_victim;
        n_found  = r_found;
        n_cycle  = r_cycle;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_check) begin
                        n_state = S_START;
                        n_start = '0;
                        n_cycle = 1'b0;
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
            S_START: begin
                n_node = AW'(CW'(r_start));
                n_step = '0;
                if (r_waiting[r_start]) begin
                    n_state = S_TEST;
                end else if (r_start == LAST_IDX) begin
                    n_state = S_DECIDE;
                end else begin
                    n_start = r_start + 1'b1;
                end
            end
            S_TEST: begin
                if (!node_ok || !r_waiting[node_idx]) begin
                    // The chain leaves the waiting set: no loop from this start.
                    if (r_start == LAST_IDX) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_start = r_start + 1'b1;
                        n_state = S_START;
                    end
                end else if (r_step == LAST_STEP) begin
                    // Every step stayed inside the waiting set, so a node repeated.
                    n_cycle  = 1'b1;
                    n_scan   = '0;
                    n_best   = '0;
                    n_victim = '0;
                    n_found  = 1'b0;
                    n_state  = S_SCAN_RD;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_node  = r_wf_q;
                n_step  = r_step + 1'b1;
                n_state = S_TEST;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_waiting[r_scan] && (wait_ms > r_best)) begin
                    n_best   = wait_ms;
                    n_victim = r_scan;
                    n_found  = 1'b1;
                end
                if (r_scan == LAST_IDX) begin
                    n_state = S_DECIDE;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cycle <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cycle <= n_cycle;
            r_found <= n_found;
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_step   <= n_step;
        r_node   <= n_node;
        r_scan   <= n_scan;
        r_best   <= n_best;
        r_victim <= n_victim;
        if (in_acc) begin
            r_now <= i_now_ms;
        end
    end

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= wgdd_pkg::TIMEOUT_RESET_MS;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // Waiting bits: set by record, dropped by clear or by a forced release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= '0;
        end else if (in_acc && agent_ok && is_record) begin
            r_waiting[agent_idx] <= 1'b1;
        end else if (in_acc && agent_ok && is_clear) begin
            r_waiting[agent_idx] <= 1'b0;
        end else if (r_state == S_DECIDE && out_load && out_rel) begin
            r_waiting[r_victim] <= 1'b0;
        end
    end

    // Edge table: written by record, read along the walk.
    always_ff @(posedge i_clk) begin
        if (in_acc && agent_ok && is_record) begin
            r_wf_mem[agent_idx] <= i_blocker;
        end
        r_wf_q <= r_wf_mem[node_idx];
    end

    // Start-time table: written on a record of an agent not yet waiting, read during the scan.
    always_ff @(posedge i_clk) begin
        if (in_acc && agent_ok && is_record && !r_waiting[agent_idx]) begin
            r_ws_mem[agent_idx] <= i_now_ms;
        end
        r_ws_q <= r_ws_mem[r_scan];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_DECIDE) begin
                o_cycle_found  <= out_cycle;
                o_victim_valid <= out_vv;
                o_victim       <= out_vv ? victim_x[AW-1:0] : '0;
                o_release_res  <= out_rel;
            end else begin
                o_cycle_found  <= 1'b0;
                o_victim_valid <= 1'b0;
                o_victim       <= '0;
                o_release_res  <= 1'b0;
            end
        end
    end

    // A check word starts the walk at the first agent.
    a_check_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_check) |=> (r_state == S_START && r_start == '0))
        else $error("check word did not start the walk");

    // A record of a valid agent marks it waiting.
    a_record_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_record && agent_ok) |=> r_waiting[$past(agent_idx)])
        else $error("recorded agent not marked waiting");

    // A release or a victim is only reported together with a found cycle.
    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_release_res || o_victim_valid)) |->
            (o_cycle_found && o_victim_valid))
        else $error("victim or release without a cycle");

    // A forced release drops the victim from the table.
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && out_load && out_rel) |=> !r_waiting[$past(r_victim)])
        else $error("released victim still waiting");

endmodule

`default_nettype wire
